// File: rtl/lmhe_pkg.sv
`timescale 1ns / 1ps
package lmhe_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_TRANS_MUL1,
      ST_TRANS_MUL2,
      ST_SAMP_RD,
      ST_SAMP_WR,
      ST_SAMP_MUL,
      ST_SUM_RD,
      ST_SUM_LOG,
      ST_SUM_ACC,
      ST_FIN_LOG,
      ST_FIN_DIV,
      ST_FIN_OUT,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      LG_IDLE,
      LG_NORM,
      LG_SQ,
      LG_MULLO,
      LG_MULHI,
      LG_DONE
   } log_state_type;

   localparam logic [1:0] CSR_START_VALUE     = 2'd0;
   localparam logic [1:0] CSR_TRANSIENT_STEPS = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_STEPS    = 2'd2;

   localparam logic [31:0] START_VALUE_RESET     = 32'd858993459;
   localparam logic [15:0] TRANSIENT_STEPS_RESET = 16'd2000;
   localparam logic [23:0] SAMPLE_STEPS_RESET    = 24'd5000000;

   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
   localparam int ENTROPY_W = 21;
   localparam int SUM_W = 48;

endpackage

// File: rtl/lmhe_req_if.sv
`timescale 1ns / 1ps
interface lmhe_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] growth_rate;
   modport source (output valid, output growth_rate, input ready);
   modport sink (input valid, input growth_rate, output ready);
endinterface

// File: rtl/lmhe_rsp_if.sv
`timescale 1ns / 1ps
interface lmhe_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [20:0] entropy;
   modport source (output valid, output entropy, input ready);
   modport sink (input valid, input entropy, output ready);
endinterface

// File: rtl/lmhe_ram.sv
`timescale 1ns / 1ps
module lmhe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/lmhe_log.sv
`timescale 1ns / 1ps
// Natural log of an unsigned integer in Q.16, one squaring per cycle.
// From start to done it runs normalize, twenty squarings and the two ln 2 product halves.
module lmhe_log (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic [25:0] result
);
   localparam logic [15:0] LN2_LO = lmhe_pkg::LN2_Q32[15:0];
   localparam logic [15:0] LN2_HI = lmhe_pkg::LN2_Q32[31:16];

   lmhe_pkg::log_state_type state_ff, state_in;
   logic [31:0] val_ff, val_in;
   logic [4:0]  k_ff, k_in;
   logic [31:0] m_ff, m_in;
   logic [19:0] frac_ff, frac_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [51:0] lo_ff, lo_in;
   logic [25:0] res_ff, res_in;
   logic [63:0] sq;
   logic [31:0] sq_m;
   logic [4:0]  top;
   logic [24:0] lg;
   logic [56:0] hi_prod;

   always_comb begin
      top = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (val_ff[i]) begin
            top = 5'(i);
         end
      end
   end

   assign sq      = m_ff * m_ff;
   assign sq_m    = sq[61:30];
   assign lg      = {k_ff, frac_ff};
   assign hi_prod = lg * LN2_HI;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmhe_pkg::LG_IDLE:
            if (start) state_in = lmhe_pkg::LG_NORM;
         lmhe_pkg::LG_NORM:
            state_in = (val_ff == 32'd0) ? lmhe_pkg::LG_DONE : lmhe_pkg::LG_SQ;
         lmhe_pkg::LG_SQ:
            if (cnt_ff == 5'd0) state_in = lmhe_pkg::LG_MULLO;
         lmhe_pkg::LG_MULLO: state_in = lmhe_pkg::LG_MULHI;
         lmhe_pkg::LG_MULHI: state_in = lmhe_pkg::LG_DONE;
         lmhe_pkg::LG_DONE:  state_in = lmhe_pkg::LG_IDLE;
         default: state_in = lmhe_pkg::LG_IDLE;
      endcase
   end

   always_comb begin
      val_in   = val_ff;
      k_in     = k_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      lo_in    = lo_ff;
      res_in   = res_ff;
      unique case (state_ff)
         lmhe_pkg::LG_IDLE: begin
            if (start) begin
               val_in = value;
            end
         end
         lmhe_pkg::LG_NORM: begin
            k_in    = top;
            m_in    = (top >= 5'd30) ? (val_ff >> (top - 5'd30))
                                     : (val_ff << (5'd30 - top));
            frac_in = '0;
            cnt_in  = 5'd19;
            if (val_ff == 32'd0) begin
               res_in = '0;
            end
         end
         lmhe_pkg::LG_SQ: begin
            if (sq_m[31]) begin
               m_in = sq_m >> 1;
               frac_in = frac_ff | (20'd1 << cnt_ff);
            end else begin
               m_in = sq_m;
            end
            cnt_in = cnt_ff - 5'd1;
         end
         lmhe_pkg::LG_MULLO: begin
            lo_in = {27'd0, lg} * {36'd0, LN2_LO};
         end
         lmhe_pkg::LG_MULHI: begin
            // (lg*hi*2^16 + lg*lo) >> 36
            res_in = 26'(({16'd0, hi_prod, 16'd0} + {37'd0, lo_ff}) >> 36);
         end
         lmhe_pkg::LG_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmhe_pkg::LG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff  <= val_in;
      k_ff    <= k_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      lo_ff   <= lo_in;
      res_ff  <= res_in;
   end

   assign done   = (state_ff == lmhe_pkg::LG_DONE);
   assign result = res_ff;
endmodule

// File: rtl/logistic_map_histogram_entropy_core.sv
`timescale 1ns / 1ps
// Logistic-map histogram entropy: each growth rate transfer starts a run that clears the
// histogram RAM, iterates the map (each transient step forms its two products through one
// shared 32x32 multiplier; each sample step forms the bin index, does the RAM
// read-modify-write and forms the two map products), then walks every bin with a shared
// log unit (empty bins skip the log) and finishes with two logs, a 48-bit restoring divide
// and a saturation step. With N zero the finish skips the logs and the divide and the
// result is zero. The request side is not ready during a run.
module logistic_map_histogram_entropy_core #(
   parameter int BINS = 1024,
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   lmhe_req_if.sink    req,
   lmhe_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = $clog2(BINS);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [31:0] BINS_M1 = 32'(BINS - 1);

   lmhe_pkg::state_type state_ff, state_in;

   logic [31:0] start_ff;
   logic [15:0] trans_ff;
   logic [23:0] samp_ff;

   logic [31:0] r_ff, r_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] p_ff, p_in;
   logic [23:0] cnt_ff, cnt_in;
   logic [AW:0] bin_ff, bin_in;
   logic [47:0] sum_ff, sum_in;
   logic [25:0] lnn_ff, lnn_in;
   logic        fin_sel_ff, fin_sel_in;
   logic [5:0]  div_ff, div_in;
   logic [47:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic signed [20:0] ent_ff, ent_in;
   logic [COUNT_BITS-1:0] c_ff, c_in;

   // Shared multiplier.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [AW-1:0] idx;
   logic [31:0] idx_raw;
   logic         ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [COUNT_BITS-1:0] ram_wd, ram_rd;

   logic        lg_start, lg_done;
   logic [31:0] lg_value;
   logic [25:0] lg_res;

   logic [24:0] rem_sh;
   logic signed [49:0] s_full;

   lmhe_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   lmhe_log u_log (
      .clock(clock), .reset(reset), .start(lg_start), .value(lg_value),
      .done(lg_done), .result(lg_res)
   );

   assign idx_raw = mul_p[63:32];
   assign idx = (idx_raw > BINS_M1) ? AW'(BINS - 1) : idx_raw[AW-1:0];
   assign rem_sh = {rem_ff[23:0], quo_ff[47]};
   assign s_full = 50'(signed'({24'd0, lnn_ff})) - 50'(signed'({24'd0, lg_res}))
                 - 50'(signed'({2'd0, quo_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= lmhe_pkg::START_VALUE_RESET;
         trans_ff <= lmhe_pkg::TRANSIENT_STEPS_RESET;
         samp_ff  <= lmhe_pkg::SAMPLE_STEPS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lmhe_pkg::CSR_START_VALUE:     start_ff <= csr_data;
            lmhe_pkg::CSR_TRANSIENT_STEPS: trans_ff <= csr_data[15:0];
            lmhe_pkg::CSR_SAMPLE_STEPS:    samp_ff  <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmhe_pkg::ST_IDLE:
            if (req.valid) state_in = lmhe_pkg::ST_CLEAR;
         lmhe_pkg::ST_CLEAR:
            if (bin_ff[AW-1:0] == AW'(BINS - 1)) begin
               state_in = (trans_ff != 16'd0) ? lmhe_pkg::ST_TRANS_MUL1
                        : (samp_ff != 24'd0) ? lmhe_pkg::ST_SAMP_RD : lmhe_pkg::ST_SUM_RD;
            end
         lmhe_pkg::ST_TRANS_MUL1: state_in = lmhe_pkg::ST_TRANS_MUL2;
         lmhe_pkg::ST_TRANS_MUL2:
            if (cnt_ff == 24'd0) begin
               state_in = (samp_ff != 24'd0) ? lmhe_pkg::ST_SAMP_RD : lmhe_pkg::ST_SUM_RD;
            end else begin
               state_in = lmhe_pkg::ST_TRANS_MUL1;
            end
         lmhe_pkg::ST_SAMP_RD: state_in = lmhe_pkg::ST_SAMP_WR;
         lmhe_pkg::ST_SAMP_WR:
            state_in = (cnt_ff == 24'd0) ? lmhe_pkg::ST_SUM_RD : lmhe_pkg::ST_SAMP_MUL;
         lmhe_pkg::ST_SAMP_MUL: state_in = lmhe_pkg::ST_SAMP_RD;
         lmhe_pkg::ST_SUM_RD: state_in = lmhe_pkg::ST_SUM_LOG;
         lmhe_pkg::ST_SUM_LOG:
            if (ram_rd == '0) begin
               state_in = (bin_ff[AW-1:0] == AW'(BINS - 1)) ? lmhe_pkg::ST_FIN_LOG
                                                          : lmhe_pkg::ST_SUM_RD;
            end else begin
               state_in = lmhe_pkg::ST_SUM_ACC;
            end
         lmhe_pkg::ST_SUM_ACC:
            if (lg_done) begin
               state_in = (bin_ff[AW-1:0] == AW'(BINS - 1)) ? lmhe_pkg::ST_FIN_LOG
                                                          : lmhe_pkg::ST_SUM_RD;
            end
         lmhe_pkg::ST_FIN_LOG:
            if (samp_ff == 24'd0) state_in = lmhe_pkg::ST_OUT;
            else if (lg_done && fin_sel_ff) state_in = lmhe_pkg::ST_FIN_DIV;
         lmhe_pkg::ST_FIN_DIV:
            if (div_ff == 6'd47) state_in = lmhe_pkg::ST_FIN_OUT;
         lmhe_pkg::ST_FIN_OUT: state_in = lmhe_pkg::ST_OUT;
         lmhe_pkg::ST_OUT:
            if (rsp.ready) state_in = lmhe_pkg::ST_IDLE;
         default: state_in = lmhe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      r_in = r_ff; x_in = x_ff; p_in = p_ff; cnt_in = cnt_ff; bin_in = bin_ff;
      sum_in = sum_ff; lnn_in = lnn_ff; fin_sel_in = fin_sel_ff; div_in = div_ff;
      quo_in = quo_ff; rem_in = rem_ff; ent_in = ent_ff; c_in = c_ff;
      mul_a = x_ff; mul_b = BINS_M1;
      ram_we = 1'b0; ram_wa = bin_ff[AW-1:0]; ram_wd = '0; ram_ra = idx;
      lg_start = 1'b0; lg_value = 32'(ram_rd);
      unique case (state_ff)
         lmhe_pkg::ST_IDLE: begin
            r_in = req.growth_rate; x_in = start_ff; bin_in = '0; sum_in = '0;
            div_in = '0;
            cnt_in = (trans_ff != 16'd0) ? 24'(trans_ff - 16'd1) : 24'd0;
         end
         lmhe_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            bin_in = bin_ff + 1'b1;
            if (bin_ff[AW-1:0] == AW'(BINS - 1)) begin
               bin_in = '0;
               if (trans_ff == 16'd0) cnt_in = samp_ff - 24'd1;
            end
         end
         lmhe_pkg::ST_TRANS_MUL1: begin
            mul_b = 32'(33'h1_0000_0000 - {1'b0, x_ff});
            p_in = mul_p[63:32];
            if (x_ff == 32'd0) p_in = '0;
         end
         lmhe_pkg::ST_TRANS_MUL2: begin
            mul_a = r_ff; mul_b = p_ff;
            x_in = (mul_p[63:62] != 2'd0) ? 32'hFFFF_FFFF : mul_p[61:30];
            cnt_in = cnt_ff - 24'd1;
            if (cnt_ff == 24'd0) cnt_in = samp_ff - 24'd1;
         end
         lmhe_pkg::ST_SAMP_RD: begin
            // Bin index of the current x; the RAM read is issued here.
            ram_ra = idx;
            bin_in = {1'b0, idx};
         end
         lmhe_pkg::ST_SAMP_WR: begin
            ram_we = 1'b1;
            ram_wa = bin_ff[AW-1:0];
            ram_wd = (ram_rd == CMAX) ? ram_rd : ram_rd + 1'b1;
            cnt_in = cnt_ff - 24'd1;
            // The multiplier is free during the write, so x*(1-x) is formed here.
            mul_b = 32'(33'h1_0000_0000 - {1'b0, x_ff});
            p_in = (x_ff == 32'd0) ? 32'd0 : mul_p[63:32];
            if (cnt_ff == 24'd0) bin_in = '0;
         end
         lmhe_pkg::ST_SAMP_MUL: begin
            mul_a = r_ff; mul_b = p_ff;
            x_in = (mul_p[63:62] != 2'd0) ? 32'hFFFF_FFFF : mul_p[61:30];
         end
         lmhe_pkg::ST_SUM_RD: begin
            ram_ra = bin_ff[AW-1:0];
         end
         lmhe_pkg::ST_SUM_LOG: begin
            c_in = ram_rd;
            lg_value = 32'(ram_rd);
            if (ram_rd != '0) lg_start = 1'b1;
            if (ram_rd == '0) begin
               bin_in = bin_ff + 1'b1;
               if (bin_ff[AW-1:0] == AW'(BINS - 1)) begin
                  lg_start = 1'b0;
               end
            end
            fin_sel_in = 1'b0;
         end
         lmhe_pkg::ST_SUM_ACC: begin
            mul_a = 32'(c_ff); mul_b = 32'(lg_res);
            if (lg_done) begin
               sum_in = sum_ff + mul_p[47:0];
               bin_in = bin_ff + 1'b1;
            end
         end
         lmhe_pkg::ST_FIN_LOG: begin
            if (!fin_sel_ff) begin
               lg_value = 32'(samp_ff);
               if (!lg_done) lg_start = (div_ff != 6'd63);
               div_in = 6'd63;
               if (lg_done) begin
                  lnn_in = lg_res; fin_sel_in = 1'b1; div_in = 6'd62;
               end
            end else begin
               lg_value = BINS_M1;
               if (div_ff == 6'd62) begin
                  lg_start = 1'b1; div_in = 6'd61;
               end
               if (lg_done) begin
                  div_in = '0; quo_in = sum_ff; rem_in = '0;
               end
            end
            if (samp_ff == 24'd0) ent_in = '0;
         end
         lmhe_pkg::ST_FIN_DIV: begin
            quo_in = {quo_ff[46:0], 1'b0};
            if (rem_sh >= {1'b0, samp_ff}) begin
               rem_in = rem_sh - {1'b0, samp_ff};
               quo_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh;
            end
            div_in = div_ff + 6'd1;
         end
         lmhe_pkg::ST_FIN_OUT: begin
            if (s_full > 50'sd1048575) ent_in = 21'sd1048575;
            else if (s_full < -50'sd1048576) ent_in = -21'sd1048576;
            else ent_in = s_full[20:0];
         end
         lmhe_pkg::ST_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmhe_pkg::ST_IDLE;
         fin_sel_ff <= 1'b0;
         div_ff <= '0;
      end else begin
         state_ff <= state_in;
         fin_sel_ff <= fin_sel_in;
         div_ff <= div_in;
      end
      r_ff <= r_in; p_ff <= p_in; cnt_ff <= cnt_in;
      sum_ff <= sum_in; lnn_ff <= lnn_in; quo_ff <= quo_in;
      rem_ff <= rem_in; ent_ff <= ent_in; c_ff <= c_in;
      x_ff <= x_in;
      bin_ff <= bin_in;
   end

   assign req.ready = (state_ff == lmhe_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == lmhe_pkg::ST_OUT);
   assign rsp.entropy = ent_ff;
endmodule

// File: dv/tb_lmhe_channel_if.sv
`timescale 1ns / 1ps
// The channels come with the block: lmhe_req_if carries growth_rate and lmhe_rsp_if carries
// entropy, each with valid, ready and source and sink modports. This file defines the
// testbench's own view of those transfers and nothing else.
package tb_lmhe_types_pkg;
   typedef logic [31:0] growth_rate_type;
   typedef logic signed [20:0] entropy_type;
endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   localparam int NUM_BINS = 1024;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Holds the expected entropy of every accepted growth rate and checks the results.
   class EntropyScoreboard;
      logic [31:0] start_value;
      logic [15:0] transient_steps;
      logic [23:0] sample_steps;
      int unsigned counts[NUM_BINS];
      tb_lmhe_types_pkg::entropy_type expected_entropy[$];
      int errors;

      function new();
         start_value = lmhe_pkg::START_VALUE_RESET;
         transient_steps = lmhe_pkg::TRANSIENT_STEPS_RESET;
         sample_steps = lmhe_pkg::SAMPLE_STEPS_RESET;
         errors = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] data);
         case (index)
            lmhe_pkg::CSR_START_VALUE: start_value = data;
            lmhe_pkg::CSR_TRANSIENT_STEPS: transient_steps = data[15:0];
            lmhe_pkg::CSR_SAMPLE_STEPS: sample_steps = data[23:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] logistic_step(logic [31:0] x, logic [31:0] r);
         logic [63:0] p;
         logic [63:0] y;
         p = ({32'd0, x} * ((64'd1 << 32) - {32'd0, x})) >> 32;
         y = ({32'd0, r} * p) >> 30;
         if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
         return y[31:0];
      endfunction

      // Natural log in Q.16 by normalizing to Q2.30 and squaring out the fraction bits.
      function logic [63:0] ln_q16(logic [63:0] v);
         int k;
         logic [63:0] m;
         logic [63:0] lg;
         k = 0;
         if (v == 0) return 0;
         for (int i = 63; i >= 0; i--)
            if (v[i]) begin
               k = i;
               break;
            end
         m = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
         lg = 64'(k) << 20;
         for (int i = 1; i <= 20; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               lg[20 - i] = 1'b1;
            end
         end
         return (lg * {32'd0, lmhe_pkg::LN2_Q32}) >> 36;
      endfunction

      function tb_lmhe_types_pkg::entropy_type orbit_entropy(logic [31:0] r);
         logic [31:0] x;
         logic [63:0] idx;
         logic [47:0] acc;
         longint s;
         foreach (counts[i]) counts[i] = 0;
         x = start_value;
         for (int i = 0; i < transient_steps; i++) x = logistic_step(x, r);
         for (int i = 0; i < sample_steps; i++) begin
            if (i != 0) x = logistic_step(x, r);
            idx = ({32'd0, x} * (NUM_BINS - 1)) >> 32;
            if (idx > NUM_BINS - 1) idx = NUM_BINS - 1;
            if (counts[idx] < (1 << 24) - 1) counts[idx]++;
         end
         acc = 0;
         foreach (counts[i])
            if (counts[i] != 0) acc = acc + 48'(64'(counts[i]) * ln_q16(64'(counts[i])));
         if (sample_steps == 0) return 0;
         s = longint'(ln_q16(64'(sample_steps))) - longint'(ln_q16(NUM_BINS - 1))
            - longint'({16'd0, acc} / {40'd0, sample_steps});
         if (s > 1048575) s = 1048575;
         if (s < -1048576) s = -1048576;
         return tb_lmhe_types_pkg::entropy_type'(s);
      endfunction

      function void note_rate(tb_lmhe_types_pkg::growth_rate_type r);
         expected_entropy.push_back(orbit_entropy(r));
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_entropy(tb_lmhe_types_pkg::entropy_type got);
         tb_lmhe_types_pkg::entropy_type want;
         if (expected_entropy.size() == 0) begin
            report($sformatf("unexpected result entropy=%0d", got));
            return;
         end
         want = expected_entropy.pop_front();
         if (got !== want) report($sformatf("entropy got %0d want %0d", got, want));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int idle_pct = 0;
   int stall_pct = 0;

   lmhe_req_if req_if ();
   lmhe_rsp_if rsp_if ();
   EntropyScoreboard sb = new();

   logistic_map_histogram_entropy_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.growth_rate = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_entropy(rsp_if.entropy);
   end

   task write_csr(logic [1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_register(index, data);
   endtask

   task configure(logic [31:0] x0, logic [15:0] t, logic [23:0] n);
      write_csr(lmhe_pkg::CSR_START_VALUE, x0);
      write_csr(lmhe_pkg::CSR_TRANSIENT_STEPS, {16'd0, t});
      write_csr(lmhe_pkg::CSR_SAMPLE_STEPS, {8'd0, n});
   endtask

   task send_rate(tb_lmhe_types_pkg::growth_rate_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.growth_rate <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_rate(r);
      @(negedge clock);
      req_if.valid <= 1'b0;
      req_if.growth_rate <= $urandom;
   endtask

   // Registers change only once the block has delivered everything in flight.
   task drain();
      while (sb.expected_entropy.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int modes_idle[4];
      int modes_stall[4];
      modes_idle = '{0, 77, 0, 28};
      modes_stall = '{0, 0, 77, 28};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extremes of the start value, no transient, a single sample.
      configure(32'd0, 16'd0, 24'd1);
      send_rate(32'd0);
      send_rate(32'hFFFF_FFFF);
      drain();
      configure(32'hFFFF_FFFF, 16'd0, 24'd1);
      send_rate(32'h4000_0000);
      send_rate(32'hFFFF_FFFF);
      drain();
      configure(32'h8000_0000, 16'd3, 24'd40);
      send_rate(32'hFFFF_FFFF);
      send_rate(32'h8000_0000);
      send_rate(32'hC000_0000);
      send_rate(32'hE47A_E148);
      drain();
      // With no samples the result is zero.
      configure(lmhe_pkg::START_VALUE_RESET, 16'd5, 24'd0);
      send_rate(32'hF000_0000);
      send_rate($urandom);
      drain();
      // A write to an unused index must leave the registers alone.
      write_csr(CSR_UNUSED, $urandom);
      send_rate(32'hE000_0000);
      drain();
      // Longest transient once, then one long sample run.
      configure(lmhe_pkg::START_VALUE_RESET, 16'hFFFF, 24'd16);
      send_rate(32'hE000_0000);
      drain();
      configure(lmhe_pkg::START_VALUE_RESET, 16'd20, 24'd100000);
      send_rate(32'hF000_0000);
      drain();

      for (int mode = 0; mode < 4; mode++) begin
         idle_pct = modes_idle[mode];
         stall_pct = modes_stall[mode];
         for (int grp = 0; grp < 5; grp++) begin
            configure($urandom, 16'($urandom_range(300)), 24'($urandom_range(64, 1)));
            for (int i = 0; i < 5; i++) begin
               // Mostly chaotic-range rates, with the full range mixed in.
               if ($urandom_range(99) < 70) send_rate(32'hC000_0000 | ($urandom >> 2));
               else send_rate($urandom);
            end
            drain();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
